// File: rtl/krlt_pkg.sv
`default_nettype none

package krlt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MISS_VALUE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DATE_MODE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DAY    = 2'd2;

    localparam logic [31:0] MAX_DAY_RESET = 32'd65535;
    localparam logic [63:0] INT64_MAX_C = {1'b0, {63{1'b1}}};
    localparam logic [63:0] INT64_MIN_C = {1'b1, {63{1'b0}}};

    // one table entry; low and high are signed two's complement
    typedef struct packed {
        logic [63:0] key;
        logic [63:0] low;
        logic [63:0] high;
        logic [63:0] data;
    } entry_t;

    // lookup token travelling down the cell row
    typedef struct packed {
        logic        tok;
        logic        found;
        logic [63:0] value;
    } probe_t;

endpackage

`default_nettype wire

// File: rtl/krlt_cell.sv
`default_nettype none

module krlt_cell
    import krlt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // insert side
    input  wire logic        ins_en,
    input  wire entry_t      new_ent,
    input  wire entry_t      prev_ent,
    input  wire logic        prev_valid,
    input  wire logic        prev_place,
    output entry_t           ent,
    output logic             valid,
    output logic             place,
    // lookup side
    input  wire logic [63:0] q_key,
    input  wire logic [63:0] q_point,
    input  wire probe_t      probe_in,
    output probe_t           probe_out
);

    entry_t      ent_reg;
    logic        valid_reg;
    logic        tok_reg;
    logic        found_reg;
    logic [63:0] value_reg;
    logic        less;
    logic        match;

    // stored (low, high) sorts strictly before the new entry
    always_comb begin
        less = ($signed(ent_reg.low) < $signed(new_ent.low)) ||
               ((ent_reg.low == new_ent.low) &&
                ($signed(ent_reg.high) < $signed(new_ent.high)));
        place = !valid_reg || !less;
        match = valid_reg && (ent_reg.key == q_key) &&
                ($signed(ent_reg.low) <= $signed(q_point)) &&
                ($signed(q_point) <= $signed(ent_reg.high));
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end else begin
            tok_reg <= probe_in.tok;
            if (ins_en) begin
                if (prev_place) begin
                    valid_reg <= prev_valid;
                end else if (place) begin
                    valid_reg <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (ins_en) begin
            if (prev_place) begin
                ent_reg <= prev_ent;
            end else if (place) begin
                ent_reg <= new_ent;
            end
        end
        // first match along the row wins
        found_reg <= probe_in.found || match;
        if (!probe_in.found && match) begin
            value_reg <= ent_reg.data;
        end else begin
            value_reg <= probe_in.value;
        end
    end

    assign ent       = ent_reg;
    assign valid     = valid_reg;
    assign probe_out = {tok_reg, found_reg, value_reg};

endmodule

`default_nettype wire

// File: rtl/key_range_lookup_table.sv
`default_nettype none

// Sorted key/interval table held in a row of TABLE_DEPTH cells, each cell one
// entry ordered by signed (low, high), newest first among equal bounds. Items
// are taken one at a time. An insert shifts the tail of the row by one cell and
// presents its result beat after passing through the insert and done states; a
// dropped insert (table full) reports status 1. A lookup sends a token down the
// row one cell per cycle, so the row length sets how long a lookup takes. The
// next item is taken only once the previous result has been presented; a result
// beat still held by the receiver stalls the finish of the following item.
// Configuration writes are always accepted and must only be issued while the
// block is idle.
module key_range_lookup_table
    import krlt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // item channel
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_opcode,
    input  wire logic [63:0]            s_search_key,
    input  wire logic signed [63:0]     s_range_low,
    input  wire logic signed [63:0]     s_range_high,
    input  wire logic                   s_low_is_null,
    input  wire logic                   s_high_is_null,
    input  wire logic [63:0]            s_entry_data,
    input  wire logic signed [63:0]     s_query_point,
    // result channel
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [63:0]                 m_result_value,
    output logic                        m_found,
    output logic                        m_status,
    // configuration
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [63:0]            cfg_data
);

    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_INS  = 4'b0010,
        ST_LOOK = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_count_reg;
    logic                inject_reg;
    logic                full;
    logic                ins_en;
    logic                s_fire;

    logic [63:0]         miss_value_reg;
    logic                date_mode_reg;
    logic [31:0]         max_day_reg;

    entry_t              new_ent_reg;
    logic [63:0]         q_point_reg;
    logic [63:0]         fix_low, fix_high;
    logic [63:0]         low_dflt, high_dflt;
    logic [63:0]         max_day_ext;
    logic                low_ok, high_ok;

    logic [63:0]         pend_value_reg;
    logic                pend_found_reg;
    logic                pend_status_reg;
    logic                m_valid_reg;
    logic [63:0]         m_value_reg;
    logic                m_found_reg;
    logic                m_status_reg;
    logic                out_free;

    entry_t              cell_ent   [TABLE_DEPTH];
    logic                cell_valid [TABLE_DEPTH];
    logic                cell_place [TABLE_DEPTH];
    probe_t              cell_probe [TABLE_DEPTH];
    probe_t              probe_head;
    probe_t              tail;
    logic [TABLE_DEPTH-1:0] valid_vec;
    logic [TABLE_DEPTH-1:0] tok_vec;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign full      = (fill_count_reg == FILL_W'(TABLE_DEPTH));
    assign ins_en    = (state_reg == ST_INS) && !full;
    assign out_free  = !m_valid_reg || m_ready;
    assign tail      = cell_probe[TABLE_DEPTH-1];

    // bound defaults
    always_comb begin
        max_day_ext = {32'd0, max_day_reg};
        if (date_mode_reg) begin
            low_dflt  = 64'd0;
            high_dflt = max_day_ext + 64'd1;
        end else begin
            low_dflt  = INT64_MAX_C;
            high_dflt = INT64_MIN_C;
        end
        low_ok  = !date_mode_reg ||
                  ((s_range_low > 64'sd0) && (s_range_low <= $signed(max_day_ext)));
        high_ok = !date_mode_reg ||
                  ((s_range_high > 64'sd0) && (s_range_high <= $signed(max_day_ext)));
        fix_low  = (s_low_is_null  || !low_ok)  ? low_dflt  : s_range_low;
        fix_high = (s_high_is_null || !high_ok) ? high_dflt : s_range_high;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_opcode == OP_LOOKUP) ? ST_LOOK : ST_INS;
                end
            end
            ST_INS:  state_next = ST_DONE;
            ST_LOOK: begin
                if (tail.tok) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_count_reg <= '0;
            inject_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            miss_value_reg <= 64'd0;
            date_mode_reg  <= 1'b0;
            max_day_reg    <= MAX_DAY_RESET;
        end else begin
            state_reg  <= state_next;
            inject_reg <= s_fire && (s_opcode == OP_LOOKUP);
            if (ins_en) begin
                fill_count_reg <= fill_count_reg + FILL_W'(1);
            end
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MISS_VALUE: miss_value_reg <= cfg_data;
                    CFG_DATE_MODE:  date_mode_reg  <= cfg_data[0];
                    CFG_MAX_DAY:    max_day_reg    <= cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            new_ent_reg.key  <= s_search_key;
            new_ent_reg.low  <= fix_low;
            new_ent_reg.high <= fix_high;
            new_ent_reg.data <= s_entry_data;
            q_point_reg      <= s_query_point;
        end
        if (state_reg == ST_INS) begin
            pend_value_reg  <= 64'd0;
            pend_found_reg  <= 1'b0;
            pend_status_reg <= full;
        end else if ((state_reg == ST_LOOK) && tail.tok) begin
            pend_value_reg  <= tail.found ? tail.value : miss_value_reg;
            pend_found_reg  <= tail.found;
            pend_status_reg <= 1'b0;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_value_reg  <= pend_value_reg;
            m_found_reg  <= pend_found_reg;
            m_status_reg <= pend_status_reg;
        end
    end

    assign probe_head = {inject_reg, 1'b0, 64'd0};

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            krlt_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ins_en     (ins_en),
                .new_ent    (new_ent_reg),
                .prev_ent   (new_ent_reg),
                .prev_valid (1'b0),
                .prev_place (1'b0),
                .ent        (cell_ent[i]),
                .valid      (cell_valid[i]),
                .place      (cell_place[i]),
                .q_key      (new_ent_reg.key),
                .q_point    (q_point_reg),
                .probe_in   (probe_head),
                .probe_out  (cell_probe[i])
            );
        end else begin : g_body
            krlt_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ins_en     (ins_en),
                .new_ent    (new_ent_reg),
                .prev_ent   (cell_ent[i-1]),
                .prev_valid (cell_valid[i-1]),
                .prev_place (cell_place[i-1]),
                .ent        (cell_ent[i]),
                .valid      (cell_valid[i]),
                .place      (cell_place[i]),
                .q_key      (new_ent_reg.key),
                .q_point    (q_point_reg),
                .probe_in   (cell_probe[i-1]),
                .probe_out  (cell_probe[i])
            );
        end
        assign valid_vec[i] = cell_valid[i];
        assign tok_vec[i]   = cell_probe[i].tok;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_value_reg;
    assign m_found        = m_found_reg;
    assign m_status       = m_status_reg;

    // occupied cells form a contiguous prefix matching the fill count
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (((valid_vec + 1'b1) & valid_vec) == '0) &&
        ($countones(valid_vec) == int'(fill_count_reg)))
        else $error("cell valid bits do not match fill count");

    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({tok_vec, inject_reg}))
        else $error("more than one lookup token in the row");

    a_token_only_in_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        tail.tok |-> (state_reg == ST_LOOK))
        else $error("lookup token left the row outside a lookup");

    a_found_not_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_found_reg) |-> !m_status_reg)
        else $error("result both found and dropped");

    a_fill_grows_on_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_en |=> (fill_count_reg == $past(fill_count_reg) + FILL_W'(1)))
        else $error("fill count did not advance on insert");

endmodule

`default_nettype wire
